@@ rtl/npcs_pkg.sv @@
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types and constants of the nearest palette color search block.
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int PALETTE_SIZE = 256;
  localparam int IDX_W        = $clog2(PALETTE_SIZE);
  localparam int RGB_W        = 24;
  localparam int CHAN_W       = 8;
  localparam int SQ_W         = 2 * CHAN_W;
  // Three squared channel differences sum to at most 195075.
  localparam int DIST_W       = 18;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } npcs_state_t;

  // Tag that travels with each palette entry through the scan pipeline.
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] idx;
  } npcs_tag_t;

endpackage

@@ rtl/npcs_in_if.sv @@
// ----------------------------------------------------------------------------
// npcs_in_if
// Input channel: palette writes and pixel lookups with valid/ready.
// ----------------------------------------------------------------------------
interface npcs_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  entry_index;
  logic [23:0] entry_color;
  logic [31:0] pixel_color;

  modport source (output valid, mode, entry_index, entry_color, pixel_color,
                  input ready);
  modport sink (input valid, mode, entry_index, entry_color, pixel_color,
                output ready);
endinterface

@@ rtl/npcs_out_if.sv @@
// ----------------------------------------------------------------------------
// npcs_out_if
// Output channel: one nearest palette index per lookup, with valid/ready.
// ----------------------------------------------------------------------------
interface npcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] match_index;

  modport source (output valid, match_index, input ready);
  modport sink (input valid, match_index, output ready);
endinterface

@@ rtl/nearest_palette_color_search.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Finds the palette entry nearest to an ARGB pixel in squared RGB distance.
// ----------------------------------------------------------------------------
// Usage: words arrive on in_ch. A word with mode 0 writes entry_color into
// palette entry entry_index; entries 1 to 255 are stored, a write to entry 0
// is dropped, and a write gives no result. A word with mode 1 looks up
// pixel_color and gives one word on out_ch holding match_index.
// A pixel with alpha zero maps to index 0 and skips the palette scan.
// Any other pixel is compared against entries 1 to 255, read from the
// palette memory one per cycle; ties go to the lowest index.
// One word is worked on at a time: in_ch.ready is high only while the scan
// unit is idle, which it is while a finished result still waits on out_ch.
// If the receiver stalls, the result waits in the output register, and a
// second lookup that finishes meanwhile holds until that register is free.
// Reset is synchronous; it marks every palette entry as zero and empties
// the output register. No clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_palette_color_search (
  input logic       clk,
  input logic       rst,
  npcs_in_if.sink   in_ch,
  npcs_out_if.source out_ch
);
  import npcs_pkg::*;

  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PALETTE_SIZE - 1);

  npcs_state_t      state;
  npcs_state_t      state_next;
  logic [IDX_W-1:0] addr;
  logic [RGB_W-1:0] pix_rgb;
  logic [IDX_W-1:0] best_idx;
  logic [DIST_W-1:0] best_dist;
  logic             res_valid;
  logic [7:0]       res_index;

  npcs_tag_t        rd_tag;
  npcs_tag_t        cmp_tag;
  logic [RGB_W-1:0] ent_rgb;
  logic [DIST_W-1:0] sq_dist;

  logic             in_ready;
  logic             issue;
  logic             load_result;
  logic             in_acc;
  logic             lookup_acc;
  logic             transparent;
  logic             wr_en;

  assign in_acc      = in_ch.valid && in_ready;
  assign lookup_acc  = in_acc && (in_ch.mode == MODE_LOOKUP);
  assign transparent = (in_ch.pixel_color[31:24] == 8'd0);
  assign wr_en       = in_acc && (in_ch.mode == MODE_WRITE) &&
                       (in_ch.entry_index != 8'd0) &&
                       ({1'b0, in_ch.entry_index} < 9'(PALETTE_SIZE));

  npcs_palette_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (in_ch.entry_index[IDX_W-1:0]),
    .wr_data (in_ch.entry_color),
    .rd_addr (addr),
    .rd_data (ent_rgb)
  );

  npcs_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .pix_rgb (pix_rgb),
    .ent_rgb (ent_rgb),
    .tag_in  (rd_tag),
    .sq_dist (sq_dist),
    .tag_out (cmp_tag)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (lookup_acc) begin
          state_next = transparent ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cmp_tag.vld && cmp_tag.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!res_valid || out_ch.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready    = 1'b0;
    issue       = 1'b0;
    load_result = 1'b0;
    case (state)
      ST_IDLE:   in_ready    = 1'b1;
      ST_SCAN:   issue       = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: load_result = !res_valid || out_ch.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_tag.last <= (addr == LAST_IDX);
    rd_tag.idx  <= addr;
    if (rst) begin
      state      <= ST_IDLE;
      rd_tag.vld <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rd_tag.vld <= issue;
      if (load_result) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_acc) begin
      addr     <= FIRST_IDX;
      pix_rgb  <= in_ch.pixel_color[RGB_W-1:0];
      best_idx <= '0;
    end else if (issue) begin
      addr <= addr + FIRST_IDX;
    end
    // The first entry always seeds the running best; a later one replaces
    // it only when strictly closer, so ties keep the lower index.
    if (cmp_tag.vld && (cmp_tag.idx == FIRST_IDX || sq_dist < best_dist)) begin
      best_idx  <= cmp_tag.idx;
      best_dist <= sq_dist;
    end
    if (load_result) begin
      res_index <= 8'(best_idx);
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = res_valid;
  assign out_ch.match_index = res_index;

  // Compared entries only appear while a scan is running.
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_tag.vld |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("scan pipeline entry outside a scan");

  // Entries reach the compare stage back to back in rising index order.
  a_cmp_order: assert property (@(posedge clk) disable iff (rst)
    (cmp_tag.vld && !cmp_tag.last) |=>
      (cmp_tag.vld && cmp_tag.idx == $past(cmp_tag.idx) + FIRST_IDX))
    else $error("scan pipeline skipped or reordered an entry");

  // A finished lookup never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_ch.ready) |-> !load_result)
    else $error("pending result overwritten");

endmodule

@@ rtl/npcs_palette_ram.sv @@
// ----------------------------------------------------------------------------
// npcs_palette_ram
// Palette store: one write port, one registered read port. Per-entry valid
// flops make every entry read as zero until it is first written.
// ----------------------------------------------------------------------------
module npcs_palette_ram (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [npcs_pkg::IDX_W-1:0]        wr_addr,
  input  logic [npcs_pkg::RGB_W-1:0]        wr_data,
  input  logic [npcs_pkg::IDX_W-1:0]        rd_addr,
  output logic [npcs_pkg::RGB_W-1:0]        rd_data
);
  import npcs_pkg::*;

  logic [RGB_W-1:0]        mem [PALETTE_SIZE];
  logic [PALETTE_SIZE-1:0] written;
  logic [RGB_W-1:0]        rd_word;
  logic                    rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      rd_written <= written[rd_addr];
    end
  end

  assign rd_data = rd_written ? rd_word : '0;

endmodule

@@ rtl/npcs_dist.sv @@
// ----------------------------------------------------------------------------
// npcs_dist
// Two-stage squared RGB distance: channel squares, then their sum.
// ----------------------------------------------------------------------------
module npcs_dist (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [npcs_pkg::RGB_W-1:0]    pix_rgb,
  input  logic [npcs_pkg::RGB_W-1:0]    ent_rgb,
  input  npcs_pkg::npcs_tag_t           tag_in,
  output logic [npcs_pkg::DIST_W-1:0]   sq_dist,
  output npcs_pkg::npcs_tag_t           tag_out
);
  import npcs_pkg::*;

  logic [CHAN_W-1:0] diff [3];
  logic [SQ_W-1:0]   sq   [3];
  npcs_tag_t         tag_sq;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [CHAN_W-1:0] a;
      logic [CHAN_W-1:0] b;
      a = pix_rgb[c*CHAN_W +: CHAN_W];
      b = ent_rgb[c*CHAN_W +: CHAN_W];
      diff[c] = (a > b) ? (a - b) : (b - a);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      sq[c] <= SQ_W'(diff[c] * diff[c]);
    end
    sq_dist <= DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_sq  <= '0;
      tag_out <= '0;
    end else begin
      tag_sq  <= tag_in;
      tag_out <= tag_sq;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the nearest palette color search block. A directed table
// and then random palette loads and pixel lookups are sent. A local palette
// copy predicts the nearest index unless a row fixes it; each output word
// matches the oldest expected index while both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import npcs_pkg::*;

  localparam int RANDOM_ITEMS = 1230;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    logic                 mode;
    logic [IDX_W-1:0]     idx;
    logic [RGB_W-1:0]     rgb;
    logic [31:0]          pix;
    bit                   fixed;
    logic [IDX_W-1:0]     fixed_idx;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  npcs_in_if  in_ch ();
  npcs_out_if out_ch ();

  nearest_palette_color_search u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [RGB_W-1:0] palette_copy [1:PALETTE_SIZE-1];
  logic [IDX_W-1:0] nearest_q [$];
  logic [IDX_W-1:0] want_idx;
  int               mismatches = 0;
  bit               calm = 1'b0;

  // Rows with the fixed flag carry an answer that is plain from the palette
  // contents at that point; the other rows go through the predictor.
  stim_row_t directed_rows [23] = '{
    '{MODE_LOOKUP, 8'h00, 24'h000000, 32'hFF123456, 1'b1, 8'd1},
    '{MODE_LOOKUP, 8'h00, 24'h000000, 32'h00FFFFFF, 1'b1, 8'd0},
    '{MODE_LOOKUP, 8'hFF, 24'hFFFFFF, 32'h01000000, 1'b1, 8'd1},
    '{MODE_WRITE,  8'h00, 24'hFFFFFF, 32'h00000000, 1'b0, 8'd0},
    '{MODE_LOOKUP, 8'h00, 24'h000000, 32'hFFFFFFFF, 1'b1, 8'd1},
    '{MODE_WRITE,  8'hFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0, 8'd0},
    '{MODE_LOOKUP, 8'h00, 24'h000000, 32'hFFFFFFFF, 1'b1, 8'd255},
    '{MODE_LOOKUP, 8'h00, 24'h000000, 32'h80000000, 1'b1, 8'd1},
    '{MODE_WRITE,  8'h01, 24'hFF0000, 32'h00000000, 1'b0, 8'd0},
    '{MODE_LOOKUP, 8'h00, 24'h000000, 32'hFFFF0000, 1'b1, 8'd1},
    '{MODE_LOOKUP, 8'h00, 24'h000000, 32'hFF000000, 1'b1, 8'd2},
    '{MODE_WRITE,  8'd128, 24'h00FF00, 32'h00000000, 1'b0, 8'd0},
    '{MODE_WRITE,  8'd64, 24'h00FF00, 32'h00000000, 1'b0, 8'd0},
    '{MODE_LOOKUP, 8'h00, 24'h000000, 32'hFF00FF00, 1'b1, 8'd64},
    '{MODE_WRITE,  8'd200, 24'h0000FF, 32'h00000000, 1'b0, 8'd0},
    '{MODE_LOOKUP, 8'h00, 24'h000000, 32'h7F0000F0, 1'b1, 8'd200},
    '{MODE_WRITE,  8'h02, 24'h808080, 32'h00000000, 1'b0, 8'd0},
    '{MODE_LOOKUP, 8'h00, 24'h000000, 32'hFF7F8081, 1'b0, 8'd0},
    '{MODE_LOOKUP, 8'h00, 24'h000000, 32'hFF404040, 1'b0, 8'd0},
    '{MODE_WRITE,  8'h03, 24'h010203, 32'hDEADBEEF, 1'b0, 8'd0},
    '{MODE_LOOKUP, 8'hAA, 24'h555555, 32'hFF010203, 1'b1, 8'd3},
    '{MODE_WRITE,  8'hFF, 24'h7F7F7F, 32'h00000000, 1'b0, 8'd0},
    '{MODE_LOOKUP, 8'h00, 24'h000000, 32'hFFC0C0C0, 1'b0, 8'd0}
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scans entries in rising order; a strict compare keeps the lowest index
  // on a tie.
  function automatic logic [IDX_W-1:0] nearest_entry(input logic [31:0] pix);
    int               dr, dg, db, sq_dist, best_dist;
    logic [IDX_W-1:0] best;
    if (pix[31:24] == 8'h00) return '0;
    best = '0;
    best_dist = -1;
    for (int i = 1; i < PALETTE_SIZE; i++) begin
      dr = int'(pix[23:16]) - int'(palette_copy[i][23:16]);
      dg = int'(pix[15:8]) - int'(palette_copy[i][15:8]);
      db = int'(pix[7:0]) - int'(palette_copy[i][7:0]);
      sq_dist = dr * dr + dg * dg + db * db;
      if (best_dist < 0 || sq_dist < best_dist) begin
        best_dist = sq_dist;
        best = IDX_W'(i);
      end
    end
    return best;
  endfunction

  function automatic int stall_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return stall_length();
  endfunction

  function automatic logic [7:0] coarse_chan();
    case ($urandom_range(0, 2))
      0: return 8'h00;
      1: return 8'h80;
      default: return 8'hFF;
    endcase
  endfunction

  // Coarse levels and copies of stored entries make distance ties common.
  function automatic logic [RGB_W-1:0] random_color();
    case ($urandom_range(0, 3))
      0: return {coarse_chan(), coarse_chan(), coarse_chan()};
      1: return palette_copy[$urandom_range(1, PALETTE_SIZE - 1)];
      default: return RGB_W'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_pixel();
    logic [7:0]       alpha;
    logic [RGB_W-1:0] rgb;
    alpha = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    if ($urandom_range(0, 9) < 4) begin
      rgb = palette_copy[$urandom_range(1, PALETTE_SIZE - 1)]
            ^ {5'd0, 3'($urandom), 5'd0, 3'($urandom), 5'd0, 3'($urandom)};
    end else begin
      rgb = RGB_W'($urandom);
    end
    return {alpha, rgb};
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input logic m, input logic [IDX_W-1:0] idx,
                           input logic [RGB_W-1:0] rgb, input logic [31:0] pix,
                           input bit fixed, input logic [IDX_W-1:0] fixed_idx);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.entry_index <= idx;
    in_ch.entry_color <= rgb;
    in_ch.pixel_color <= pix;
    do @(posedge clk); while (!in_ch.ready);
    if (m == MODE_WRITE) begin
      if (idx != 0 && int'(idx) < PALETTE_SIZE) palette_copy[idx] = rgb;
    end else begin
      nearest_q.push_back(fixed ? fixed_idx : nearest_entry(pix));
    end
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (nearest_q.size() != 0);
  endtask

  initial begin
    int               sent;
    int               count;
    bit               paused;
    logic [IDX_W-1:0] idx;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_WRITE;
    in_ch.entry_index <= '0;
    in_ch.entry_color <= '0;
    in_ch.pixel_color <= '0;
    foreach (palette_copy[i]) palette_copy[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].mode, directed_rows[i].idx, directed_rows[i].rgb,
                directed_rows[i].pix, directed_rows[i].fixed,
                directed_rows[i].fixed_idx);
      hold_off(sender_gap());
    end
    drain_results();

    // Rounds of a palette load followed by a run of lookups.
    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      count = $urandom_range(1, 16);
      repeat (count) begin
        idx = ($urandom_range(0, 19) == 0) ? 8'd0 : IDX_W'($urandom);
        send_word(MODE_WRITE, idx, random_color(), $urandom, 1'b0, '0);
        sent++;
        hold_off(sender_gap());
      end
      count = $urandom_range(1, 10);
      repeat (count) begin
        send_word(MODE_LOOKUP, IDX_W'($urandom), RGB_W'($urandom), random_pixel(),
                  1'b0, '0);
        sent++;
        hold_off(sender_gap());
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Receiver: runs of ready broken by stalls, with calm rounds left alone.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall = stall_length();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (nearest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: match_index %0d", out_ch.match_index);
      end else begin
        want_idx = nearest_q.pop_front();
        if (out_ch.match_index !== want_idx) begin
          mismatches++;
          if (mismatches <= 10)
            $display("match_index mismatch: expected %0d, got %0d",
                     want_idx, out_ch.match_index);
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
